FILE: rtl/core/median_peak_interval_core_assert.svh
// assertion macros for the median peak interval core
`ifndef MEDIAN_PEAK_INTERVAL_CORE_ASSERT_SVH
`define MEDIAN_PEAK_INTERVAL_CORE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpi assertion failed");

// next-cycle implication
`define MPI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpi assertion failed");

`endif

FILE: rtl/core/mpi_pkg.sv
// package: constants, word types and state types of the median peak interval core
package mpi_pkg;

    localparam int MAX_INTERVALS = 256;
    localparam int FRAME_BITS    = 24;
    localparam int CENTRE_W      = FRAME_BITS + 1;
    localparam int ADDR_W        = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int BIT_W         = $clog2(CENTRE_W);
    localparam int SAMPLE_W      = 16;
    localparam int OUT_IVL_W     = 25;
    localparam int OUT_CNT_W     = 9;

    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd16384;
    localparam logic [FRAME_BITS-1:0]      FRAME_MAX     = {FRAME_BITS{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_sample;
        logic                       last_sample;
    } t_in_word;

    typedef struct packed {
        logic [OUT_IVL_W-1:0] median_interval;
        logic [OUT_CNT_W-1:0] interval_count;
        logic                 valid_res;
        logic                 overflowed;
    } t_out_word;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [CENTRE_W-1:0] data;
    } t_store_wr;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_sel_ctrl;

    typedef struct packed {
        logic                done;
        logic [CENTRE_W-1:0] value;
    } t_sel_stat;

    typedef enum logic {
        ST_RUN,
        ST_SELECT
    } t_top_state;

    typedef enum logic {
        SEL_IDLE,
        SEL_SCAN
    } t_sel_state;

endpackage

FILE: rtl/core/mpi_select.sv
// interval store and bitwise radix rank selection over it
module mpi_select (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpi_pkg::t_store_wr i_wr,
    input  mpi_pkg::t_sel_ctrl i_ctrl,
    output mpi_pkg::t_sel_stat o_stat
);
    import mpi_pkg::*;

    logic [CENTRE_W-1:0] mem [MAX_INTERVALS];

    t_sel_state          r_state, n_state;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_issuing, n_issuing;
    logic                r_rd_vld, n_rd_vld;
    logic                r_rd_last, n_rd_last;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [CENTRE_W-1:0] r_prefix, n_prefix;
    logic                r_done, n_done;
    logic [CENTRE_W-1:0] r_q;

    logic [ADDR_W-1:0]   addr_last;
    logic [CENTRE_W-1:0] mask_hi;
    logic                match;
    logic [CNT_W-1:0]    sum;
    logic                rd_en;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SEL_IDLE;
            r_issuing <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_n      <= n_n;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_bit    <= n_bit;
        r_prefix <= n_prefix;
    end

    always_comb begin
        addr_last = ADDR_W'(r_n - 1'b1);
        mask_hi   = ({CENTRE_W{1'b1}} << r_bit) << 1;
        match     = (((r_q ^ r_prefix) & mask_hi) == '0) && !r_q[r_bit];
        sum       = r_cnt + CNT_W'(match);
        rd_en     = (r_state == SEL_SCAN) && r_issuing;

        n_state   = r_state;
        n_addr    = r_addr;
        n_issuing = r_issuing;
        n_rd_vld  = 1'b0;
        n_rd_last = 1'b0;
        n_n       = r_n;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_bit     = r_bit;
        n_prefix  = r_prefix;
        n_done    = 1'b0;

        case (r_state)
            SEL_IDLE: begin
                n_issuing = 1'b0;
                if (i_ctrl.start) begin
                    n_state   = SEL_SCAN;
                    n_n       = i_ctrl.count;
                    n_k       = i_ctrl.count >> 1;
                    n_bit     = BIT_W'(CENTRE_W - 1);
                    n_prefix  = '0;
                    n_addr    = '0;
                    n_issuing = 1'b1;
                    n_cnt     = '0;
                end
            end
            SEL_SCAN: begin
                if (r_issuing) begin
                    n_rd_vld  = 1'b1;
                    n_rd_last = (r_addr == addr_last);
                    if (r_addr == addr_last) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    if (r_rd_last) begin
                        // zeros at this bit outnumber the rank: bit stays 0
                        if (sum <= r_k) begin
                            n_prefix[r_bit] = 1'b1;
                            n_k             = r_k - sum;
                        end
                        n_cnt = '0;
                        if (r_bit == '0) begin
                            n_state = SEL_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_bit     = r_bit - 1'b1;
                            n_addr    = '0;
                            n_issuing = 1'b1;
                        end
                    end else begin
                        n_cnt = sum;
                    end
                end
            end
            default: begin
                n_state = SEL_IDLE;
            end
        endcase
    end

    assign o_stat.done  = r_done;
    assign o_stat.value = r_prefix;

    `include "median_peak_interval_core_assert.svh"

    `MPI_ASSERT_IMP(a_addr_in_range, r_issuing && r_state == SEL_SCAN, {1'b0, r_addr} < r_n)
    `MPI_ASSERT_IMP(a_start_when_idle, i_ctrl.start, r_state == SEL_IDLE)
    `MPI_ASSERT_IMP(a_rank_below_count, r_state == SEL_SCAN, r_k < r_n)
    `MPI_ASSERT_NXT(a_done_ends_scan, n_done, r_state == SEL_IDLE && r_done)

endmodule

FILE: rtl/core/median_peak_interval_core.sv
// top level: peak tracking, interval capture and median result of the core
//
// channel  direction  handshake              word
// in       input      i_in_valid/o_in_stall  sample, first_sample, last_sample
// out      output     o_out_valid/i_out_stall median_interval, interval_count, flags
// cfg      input      i_cfg_valid/o_cfg_ready threshold
//
// a sample word is taken one per cycle while no selection runs and no held result stalls a last word
// a last word with stored intervals runs a radix selection, one pass per centre bit,
// over the interval store read port, with the input stalled meanwhile
// a last word with no interval gives its result in the next cycle
// reset is synchronous and clears span state; the store holds no reset value
// a held result keeps the output word; further non-last words are still taken
module median_peak_interval_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mpi_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mpi_pkg::t_out_word         o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic signed [mpi_pkg::SAMPLE_W-1:0] i_cfg_data
);
    import mpi_pkg::*;

    t_top_state                 r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_thr;
    logic                       r_in_peak, n_in_peak;
    logic [FRAME_BITS-1:0]      r_open, n_open;
    logic [FRAME_BITS-1:0]      r_frame, n_frame;
    logic [CENTRE_W-1:0]        r_last_centre, n_last_centre;
    logic                       r_have, n_have;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_ovf, n_ovf;
    logic                       r_out_valid, n_out_valid;
    t_out_word                  r_out_word, n_out_word;

    logic                       accept;
    logic                       c_in_peak, c_have, c_ovf;
    logic [FRAME_BITS-1:0]      c_open, c_frame;
    logic [CENTRE_W-1:0]        c_last_centre, centre, ivl;
    logic [CNT_W-1:0]           c_count;
    logic                       closing, opening, full;

    t_store_wr                  sel_wr;
    t_sel_ctrl                  sel_ctrl;
    t_sel_stat                  sel_stat;

    mpi_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (sel_wr),
        .i_ctrl  (sel_ctrl),
        .o_stat  (sel_stat)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state == ST_SELECT) || (r_out_valid && i_in_word.last_sample);
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RUN;
            r_thr         <= THRESHOLD_RST;
            r_in_peak     <= 1'b0;
            r_open        <= '0;
            r_frame       <= '0;
            r_last_centre <= '0;
            r_have        <= 1'b0;
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (accept) begin
                r_in_peak     <= n_in_peak;
                r_open        <= n_open;
                r_frame       <= n_frame;
                r_last_centre <= n_last_centre;
                r_have        <= n_have;
                r_count       <= n_count;
                r_ovf         <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    always_comb begin
        // first word of a span starts from cleared state
        c_in_peak     = i_in_word.first_sample ? 1'b0 : r_in_peak;
        c_open        = i_in_word.first_sample ? '0 : r_open;
        c_frame       = i_in_word.first_sample ? '0 : r_frame;
        c_last_centre = i_in_word.first_sample ? '0 : r_last_centre;
        c_have        = i_in_word.first_sample ? 1'b0 : r_have;
        c_count       = i_in_word.first_sample ? '0 : r_count;
        c_ovf         = i_in_word.first_sample ? 1'b0 : r_ovf;

        centre  = {1'b0, c_open} + {1'b0, c_frame};
        ivl     = centre - c_last_centre;
        closing = c_in_peak && (i_in_word.sample < r_thr);
        opening = !c_in_peak && (i_in_word.sample > r_thr);
        full    = (c_count >= CNT_W'(MAX_INTERVALS));

        sel_wr.en   = accept && closing && c_have && !full;
        sel_wr.addr = c_count[ADDR_W-1:0];
        sel_wr.data = ivl;

        n_count       = sel_wr.en ? c_count + 1'b1 : c_count;
        n_ovf         = c_ovf || (closing && c_have && full);
        n_last_centre = closing ? centre : c_last_centre;
        n_have        = c_have || closing;
        n_in_peak     = closing ? 1'b0 : (opening ? 1'b1 : c_in_peak);
        n_open        = opening ? c_frame : c_open;
        n_frame       = (c_frame == FRAME_MAX) ? c_frame : c_frame + 1'b1;

        sel_ctrl.start = 1'b0;
        sel_ctrl.count = n_count;

        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;

        case (r_state)
            ST_RUN: begin
                if (accept && i_in_word.last_sample) begin
                    if (n_count == '0) begin
                        n_out_valid                = 1'b1;
                        n_out_word.median_interval = '0;
                        n_out_word.interval_count  = '0;
                        n_out_word.valid_res       = 1'b0;
                        n_out_word.overflowed      = n_ovf;
                    end else begin
                        sel_ctrl.start = 1'b1;
                        n_state        = ST_SELECT;
                    end
                end
            end
            ST_SELECT: begin
                if (sel_stat.done) begin
                    n_state                    = ST_RUN;
                    n_out_valid                = 1'b1;
                    n_out_word.median_interval = OUT_IVL_W'(sel_stat.value);
                    n_out_word.interval_count  = OUT_CNT_W'(r_count);
                    n_out_word.valid_res       = 1'b1;
                    n_out_word.overflowed      = r_ovf;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `include "median_peak_interval_core_assert.svh"

    `MPI_ASSERT_IMP(a_no_write_in_select, r_state == ST_SELECT, !sel_wr.en)
    `MPI_ASSERT_IMP(a_no_result_in_select, r_state == ST_SELECT, !r_out_valid)
    `MPI_ASSERT_IMP(a_done_only_selecting, sel_stat.done, r_state == ST_SELECT)
    `MPI_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_INTERVALS))

endmodule

FILE: dv/tb_median_peak_interval_core.sv
// testbench: directed and randomised spans for the median peak interval core, checked by a predictor
module tb_median_peak_interval_core;
    import mpi_pkg::*;

    localparam int N_DIR_ROWS      = 15;
    localparam int N_PHASES        = 8;
    localparam int N_FIXED_THR     = 6;
    localparam int DENSE_PHASE     = 2;
    localparam int PRESSURE_PHASE  = 4;
    localparam int DENSE_PEAKS     = 270;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT  = 30000;

    typedef enum logic {
        LVL_ABOVE,
        LVL_BELOW
    } t_level;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       fs;
        logic                       ls;
        logic                       typed;
        t_out_word                  res;
    } t_dir_row;

    // reset span, one-sample span, equal-to-threshold samples, report and carry on,
    // open peak at span end, restart while in a peak
    localparam t_dir_row DIR_ROWS [N_DIR_ROWS] = '{
        '{16'sd0,      1'b0, 1'b1, 1'b1, '0},
        '{16'sd0,      1'b1, 1'b1, 1'b1, '0},
        '{16'sh7FFF,   1'b1, 1'b0, 1'b0, '0},
        '{16'sh8000,   1'b0, 1'b0, 1'b0, '0},
        '{16'sd16384,  1'b0, 1'b0, 1'b0, '0},
        '{16'sd16385,  1'b0, 1'b0, 1'b0, '0},
        '{16'sd16384,  1'b0, 1'b0, 1'b0, '0},
        '{16'sd16383,  1'b0, 1'b0, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b1, 1'b0, '0},
        '{16'sd20000,  1'b0, 1'b0, 1'b0, '0},
        '{-16'sd1,     1'b0, 1'b1, 1'b0, '0},
        '{16'sh7FFF,   1'b0, 1'b1, 1'b0, '0},
        '{16'sd30000,  1'b1, 1'b0, 1'b0, '0},
        '{-16'sd5,     1'b0, 1'b0, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b1, 1'b0, '0}
    };

    localparam logic signed [SAMPLE_W-1:0] PHASE_THR [N_FIXED_THR] = '{
        16'sh8000, 16'sh7FFF, 16'sd0, 16'sd16384, -16'sd1, -16'sd12000
    };
    localparam int PHASE_ITEMS [N_PHASES] = '{60, 60, 60, 140, 140, 140, 140, 140};

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       o_in_stall;
    t_in_word                   in_word;
    logic                       o_out_valid;
    logic                       out_stall;
    t_out_word                  o_out_word;
    logic                       cfg_valid;
    logic                       o_cfg_ready;
    logic signed [SAMPLE_W-1:0] cfg_data;

    median_peak_interval_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // peak tracker state
    logic signed [SAMPLE_W-1:0] trk_threshold = THRESHOLD_RST;
    logic                       trk_in_peak = 1'b0;
    logic [FRAME_BITS-1:0]      trk_open_frame = '0;
    logic [FRAME_BITS-1:0]      trk_frame = '0;
    logic [CENTRE_W-1:0]        trk_last_centre = '0;
    logic                       trk_have_centre = 1'b0;
    logic [CENTRE_W-1:0]        trk_ivl_mem [MAX_INTERVALS];
    int                         trk_ivl_count = 0;
    logic                       trk_overflow = 1'b0;

    t_out_word pending_medians [$];
    int        error_count = 0;
    int        items_sent = 0;
    int        medians_checked = 0;
    int        thresholds_written = 0;
    int        overflow_words = 0;
    int        max_count_seen = 0;
    bit        long_hold_req = 1'b0;
    bit        tx_busy = 1'b1;
    bit        rx_busy = 1'b1;

    function automatic bit track_sample(input t_in_word w, output t_out_word res);
        logic signed [SAMPLE_W-1:0] s;
        logic [CENTRE_W-1:0]        centre;
        logic [CENTRE_W-1:0]        srt [MAX_INTERVALS];
        logic [CENTRE_W-1:0]        v;
        int                         i;
        int                         j;
        s   = w.sample;
        res = '0;
        if (w.first_sample) begin
            trk_in_peak     = 1'b0;
            trk_open_frame  = '0;
            trk_frame       = '0;
            trk_last_centre = '0;
            trk_have_centre = 1'b0;
            trk_ivl_count   = 0;
            trk_overflow    = 1'b0;
        end
        if (trk_in_peak && s < trk_threshold) begin
            centre = {1'b0, trk_open_frame} + {1'b0, trk_frame};
            if (trk_have_centre) begin
                if (trk_ivl_count < MAX_INTERVALS) begin
                    trk_ivl_mem[trk_ivl_count] = centre - trk_last_centre;
                    trk_ivl_count++;
                end else begin
                    trk_overflow = 1'b1;
                end
            end
            trk_last_centre = centre;
            trk_have_centre = 1'b1;
            trk_in_peak     = 1'b0;
        end else if (!trk_in_peak && s > trk_threshold) begin
            trk_open_frame = trk_frame;
            trk_in_peak    = 1'b1;
        end
        if (trk_frame != FRAME_MAX)
            trk_frame++;
        if (!w.last_sample)
            return 1'b0;
        for (i = 0; i < trk_ivl_count; i++) begin
            v = trk_ivl_mem[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        res.median_interval = (trk_ivl_count > 0) ? OUT_IVL_W'(srt[trk_ivl_count/2]) : '0;
        res.interval_count  = OUT_CNT_W'(trk_ivl_count);
        res.valid_res       = (trk_ivl_count > 0);
        res.overflowed      = trk_overflow;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_level(input t_level kind,
                                                              input bit clean);
        int t;
        int v;
        int r;
        t = trk_threshold;
        r = clean ? 7 : $urandom_range(0, 7);
        if (r == 0) begin
            v = t;
        end else if (r == 1) begin
            v = int'($urandom);
        end else if (kind == LVL_ABOVE) begin
            if (t == 32767)
                v = t;
            else if (r == 2)
                v = $urandom_range(0, 1) ? t + 1 : 32767;
            else
                v = t + 1 + int'($urandom_range(0, 32766 - t));
        end else begin
            if (t == -32768)
                v = t;
            else if (r == 2)
                v = $urandom_range(0, 1) ? t - 1 : -32768;
            else
                v = -32768 + int'($urandom_range(0, t + 32767));
        end
        return SAMPLE_W'(v);
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        t_out_word pred;
        int        gap;
        if ($urandom_range(0, 39) == 0)
            tx_busy = ~tx_busy;
        gap = tx_busy ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (o_in_stall);
        items_sent++;
        if (track_sample(w, pred))
            pending_medians = {pending_medians, (typed ? typed_res : pred)};
    endtask

    task automatic send_span(input t_in_word span_q [$]);
        foreach (span_q[k])
            send_word(span_q[k], 1'b0, '0);
    endtask

    task automatic send_random_span(input int peaks_max);
        t_in_word span_q [$];
        t_in_word w;
        int       n_peaks;
        int       k;
        w = '0;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                w.sample       = SAMPLE_W'($urandom);
                w.first_sample = ($urandom_range(0, 9) == 0);
                w.last_sample  = ($urandom_range(0, 5) == 0);
                span_q = {span_q, w};
            end
        end else begin
            n_peaks = $urandom_range(0, peaks_max);
            repeat ($urandom_range(0, 2)) begin
                w.sample = pick_level(LVL_BELOW, 1'b0);
                span_q = {span_q, w};
            end
            repeat (n_peaks) begin
                repeat ($urandom_range(1, 4)) begin
                    w.sample = pick_level(LVL_ABOVE, 1'b0);
                    span_q = {span_q, w};
                end
                repeat ($urandom_range(1, 4)) begin
                    w.sample = pick_level(LVL_BELOW, 1'b0);
                    span_q = {span_q, w};
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    w.sample = pick_level(LVL_ABOVE, 1'b0);
                    span_q = {span_q, w};
                end
            end
            if (span_q.size() == 0) begin
                w.sample = pick_level(LVL_BELOW, 1'b0);
                span_q = {span_q, w};
            end
            for (k = 0; k < span_q.size(); k++)
                span_q[k].last_sample = ($urandom_range(0, 39) == 0);
            span_q[0].first_sample = ($urandom_range(0, 9) != 0);
            span_q[span_q.size()-1].last_sample = ($urandom_range(0, 9) != 0);
        end
        send_span(span_q);
    endtask

    // enough clean peaks to run past the interval store, with reports along the way
    task automatic send_dense_span();
        t_in_word span_q [$];
        t_in_word w;
        w = '0;
        repeat (DENSE_PEAKS) begin
            repeat (($urandom_range(0, 3) == 0) ? 2 : 1) begin
                w.sample      = pick_level(LVL_ABOVE, 1'b1);
                w.last_sample = ($urandom_range(0, 79) == 0);
                span_q = {span_q, w};
            end
            repeat (($urandom_range(0, 3) == 0) ? 2 : 1) begin
                w.sample      = pick_level(LVL_BELOW, 1'b1);
                w.last_sample = ($urandom_range(0, 79) == 0);
                span_q = {span_q, w};
            end
        end
        span_q[0].first_sample = 1'b1;
        span_q[span_q.size()-1].last_sample = 1'b1;
        send_span(span_q);
    endtask

    task automatic write_threshold(input logic signed [SAMPLE_W-1:0] thr);
        in_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        trk_threshold = thr;
        thresholds_written++;
    endtask

    task automatic check_median(input t_out_word got);
        t_out_word want;
        if (pending_medians.size() == 0) begin
            $error("unexpected median word: %p", got);
            error_count++;
            return;
        end
        want = pending_medians.pop_front();
        medians_checked++;
        if (got.overflowed)
            overflow_words++;
        if (int'(got.interval_count) > max_count_seen)
            max_count_seen = int'(got.interval_count);
        if (got.median_interval !== want.median_interval) begin
            $error("median_interval: expected %0d, got %0d",
                   want.median_interval, got.median_interval);
            error_count++;
        end
        if (got.interval_count !== want.interval_count) begin
            $error("interval_count: expected %0d, got %0d",
                   want.interval_count, got.interval_count);
            error_count++;
        end
        if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0b, got %0b", want.valid_res, got.valid_res);
            error_count++;
        end
        if (got.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
            error_count++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin : rx_side
        int hold;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_busy = ~rx_busy;
            hold = rx_busy ? $urandom_range(0, 15) : 0;
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!o_out_valid);
            check_median(o_out_word);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("median_peak_interval_core regression: fail");
        $finish;
    end

    initial begin : main_seq
        t_in_word w;
        int       p;
        int       i;
        int       phase_end;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIR_ROWS; i++) begin
            w.sample       = DIR_ROWS[i].smp;
            w.first_sample = DIR_ROWS[i].fs;
            w.last_sample  = DIR_ROWS[i].ls;
            send_word(w, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end

        for (p = 0; p < N_PHASES; p++) begin
            write_threshold((p < N_FIXED_THR) ? PHASE_THR[p] : SAMPLE_W'($urandom));
            if (p == DENSE_PHASE)
                send_dense_span();
            if (p == PRESSURE_PHASE)
                long_hold_req = 1'b1;
            phase_end = items_sent + PHASE_ITEMS[p];
            while (items_sent < phase_end)
                send_random_span((p == PRESSURE_PHASE) ? 2 :
                                 ($urandom_range(0, 9) == 0) ? 30 : 8);
        end

        in_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d samples sent, %0d median words checked, %0d threshold writes",
                 items_sent, medians_checked, thresholds_written);
        $display("largest interval count reported %0d, %0d words with the overflow flag",
                 max_count_seen, overflow_words);
        if (error_count == 0)
            $display("median_peak_interval_core regression: pass");
        else
            $display("median_peak_interval_core regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mpi_pkg.sv
rtl/core/mpi_select.sv
rtl/core/median_peak_interval_core.sv
dv/tb_median_peak_interval_core.sv
